>>> rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; included by checker modules only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> rtl/c2s_pkg.sv
// Types, constants and helpers for the stride-2 convolution unit.
// Depends on nothing; imported by the front, queue, back and top modules.
package c2s_pkg;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_HEIGHT_DEF   = 32;
    localparam int MAX_WIDTH_DEF    = 32;
    localparam int MAX_FILTERS_DEF  = 16;
    localparam int MAX_KERNEL_DEF   = 5;

    localparam int SUM_W = 48;
    localparam int SAMPLE_W = 16;
    localparam int IN_W = 40;      // 36 payload bits padded to bytes

    typedef enum logic [1:0] {
        FUNC_LOAD_WEIGHT = 2'd0,
        FUNC_LOAD_PIXEL  = 2'd1,
        FUNC_COMPUTE     = 2'd2,
        FUNC_UNUSED      = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_NUM_CHANNELS  = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_IMAGE_WIDTH   = 3'd2,
        CFG_NUM_FILTERS   = 3'd3,
        CFG_KERNEL_HEIGHT = 3'd4,
        CFG_KERNEL_WIDTH  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } bk_state_t;

    // Compute job handed from the front part to the back part.
    typedef struct packed {
        logic       err;
        logic [3:0] filter;
        logic [4:0] row;
        logic [4:0] col;
    } job_t;
endpackage

>>> rtl/c2s_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module c2s_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/c2s_front.sv
// Front part: takes input transfers, writes loads to the stores and
// classifies compute requests into jobs for the queue. Uses c2s_pkg.
module c2s_front #(
    parameter int MAX_CHANNELS = c2s_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = c2s_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FILTERS  = c2s_pkg::MAX_FILTERS_DEF,
    parameter int MAX_KERNEL   = c2s_pkg::MAX_KERNEL_DEF,
    parameter int W_DEPTH      = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL,
    parameter int I_DEPTH      = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH
) (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [c2s_pkg::IN_W-1:0]   s_tdata,
    input  logic [4:0]                 num_channels,
    input  logic [5:0]                 image_height,
    input  logic [5:0]                 image_width,
    input  logic [4:0]                 num_filters,
    input  logic [2:0]                 kernel_height,
    input  logic [2:0]                 kernel_width,
    output logic                       w_we,
    output logic [$clog2(W_DEPTH)-1:0] w_waddr,
    output logic                       i_we,
    output logic [$clog2(I_DEPTH)-1:0] i_waddr,
    output logic [15:0]                wr_data,
    output logic                       job_push,
    output c2s_pkg::job_t              job,
    input  logic                       job_full,
    input  logic                       job_empty,
    input  logic                       back_busy
);
    import c2s_pkg::*;
    localparam int WA = $clog2(W_DEPTH);
    localparam int IA = $clog2(I_DEPTH);

    logic [1:0] func;
    logic [3:0] f, c;
    logic [4:0] row, col;
    logic       acc, cfg_ok, req_ok;
    logic [5:0] h_out, w_out;

    assign func = s_tdata[1:0];
    assign f    = s_tdata[5:2];
    assign c    = s_tdata[9:6];
    assign row  = s_tdata[14:10];
    assign col  = s_tdata[19:15];
    assign wr_data = s_tdata[35:20];

    // A compute waits for queue room; any other item waits until no earlier
    // compute is queued or still reading the stores.
    assign s_tready = (func == FUNC_COMPUTE) ? !job_full : (job_empty && !back_busy);
    assign acc = s_tvalid && s_tready;

    always_comb begin
        cfg_ok = (num_channels != 0) && (32'(num_channels) <= MAX_CHANNELS)
              && (image_height != 0) && (32'(image_height) <= MAX_HEIGHT)
              && (image_width != 0) && (32'(image_width) <= MAX_WIDTH)
              && (num_filters != 0) && (32'(num_filters) <= MAX_FILTERS)
              && (kernel_height != 0) && (32'(kernel_height) <= MAX_KERNEL)
              && (kernel_width != 0) && (32'(kernel_width) <= MAX_KERNEL)
              && (6'(kernel_height) <= image_height)
              && (6'(kernel_width) <= image_width);
        h_out = 6'd1 + ((image_height - 6'(kernel_height)) >> 1);
        w_out = 6'd1 + ((image_width - 6'(kernel_width)) >> 1);
        req_ok = cfg_ok && (5'(f) < num_filters) && (6'(row) < h_out)
              && (6'(col) < w_out);
    end

    assign w_we = acc && (func == FUNC_LOAD_WEIGHT) && (32'(f) < MAX_FILTERS)
               && (32'(c) < MAX_CHANNELS) && (32'(row) < MAX_KERNEL)
               && (32'(col) < MAX_KERNEL);
    assign w_waddr = WA'(((32'(f) * MAX_CHANNELS + 32'(c)) * MAX_KERNEL + 32'(row))
                         * MAX_KERNEL + 32'(col));
    assign i_we = acc && (func == FUNC_LOAD_PIXEL) && (32'(c) < MAX_CHANNELS)
               && (32'(row) < MAX_HEIGHT) && (32'(col) < MAX_WIDTH);
    assign i_waddr = IA'((32'(c) * MAX_HEIGHT + 32'(row)) * MAX_WIDTH + 32'(col));

    assign job_push = acc && (func == FUNC_COMPUTE);
    assign job.err = !req_ok;
    assign job.filter = f;
    assign job.row = row;
    assign job.col = col;
endmodule

>>> rtl/c2s_queue.sv
// Short job queue between front and back parts.
// Uses c2s_pkg for the job type.
module c2s_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  c2s_pkg::job_t din,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output c2s_pkg::job_t dout
);
    import c2s_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t           slot_reg [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [AW:0]    cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (32'(wp_reg) == DEPTH-1) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (32'(rp_reg) == DEPTH-1) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> rtl/c2s_back.sv
// Back part: walks channels and kernel taps of one job, one
// multiply-accumulate a cycle, and holds the result. Uses c2s_pkg.
module c2s_back #(
    parameter int MAX_CHANNELS = c2s_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = c2s_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FILTERS  = c2s_pkg::MAX_FILTERS_DEF,
    parameter int MAX_KERNEL   = c2s_pkg::MAX_KERNEL_DEF,
    parameter int W_DEPTH      = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL,
    parameter int I_DEPTH      = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       job_empty,
    input  c2s_pkg::job_t              job,
    output logic                       job_pop,
    output logic                       busy,
    input  logic [4:0]                 num_channels,
    input  logic [2:0]                 kernel_height,
    input  logic [2:0]                 kernel_width,
    output logic [$clog2(W_DEPTH)-1:0] w_raddr,
    input  logic [15:0]                w_rdata,
    output logic [$clog2(I_DEPTH)-1:0] i_raddr,
    input  logic [15:0]                i_rdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [c2s_pkg::SUM_W-1:0]  sum_out,
    output logic                       err_out
);
    import c2s_pkg::*;
    localparam int WA = $clog2(W_DEPTH);
    localparam int IA = $clog2(I_DEPTH);

    bk_state_t  state_reg, state_next;
    logic [4:0] ch_reg, ch_next;
    logic [2:0] r_reg, r_next, s_reg, s_next;
    logic       last_tap;
    logic       rd_v_reg, mul_v_reg;
    logic signed [31:0] prod_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic       err_reg;
    job_t       cur_reg;

    assign last_tap = (s_reg == kernel_width - 3'd1) && (r_reg == kernel_height - 3'd1)
                   && (ch_reg == num_channels - 5'd1);
    assign w_raddr = WA'(((32'(cur_reg.filter) * MAX_CHANNELS + 32'(ch_reg)) * MAX_KERNEL
                          + 32'(r_reg)) * MAX_KERNEL + 32'(s_reg));
    assign i_raddr = IA'((32'(ch_reg) * MAX_HEIGHT + 32'({cur_reg.row, 1'b0}) + 32'(r_reg))
                         * MAX_WIDTH + 32'({cur_reg.col, 1'b0}) + 32'(s_reg));

    // Store reads are issued only while walking the taps
    assign busy = (state_reg == ST_RUN);

    always_comb begin
        state_next = state_reg;
        ch_next = ch_reg;
        r_next = r_reg;
        s_next = s_reg;
        job_pop = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!job_empty) begin
                    job_pop = 1'b1;
                    ch_next = '0;
                    r_next = '0;
                    s_next = '0;
                    state_next = job.err ? ST_OUT : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_tap) begin
                    state_next = ST_DRAIN;
                end else if (s_reg == kernel_width - 3'd1) begin
                    s_next = '0;
                    if (r_reg == kernel_height - 3'd1) begin
                        r_next = '0;
                        ch_next = ch_reg + 5'd1;
                    end else begin
                        r_next = r_reg + 3'd1;
                    end
                end else begin
                    s_next = s_reg + 3'd1;
                end
            end
            ST_DRAIN: begin
                if (!rd_v_reg && !mul_v_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rd_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            rd_v_reg <= (state_reg == ST_RUN);
            mul_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg <= ch_next;
        r_reg <= r_next;
        s_reg <= s_next;
        prod_reg <= $signed(w_rdata) * $signed(i_rdata);
        if (job_pop) begin
            cur_reg <= job;
            err_reg <= job.err;
            acc_reg <= '0;
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign sum_out = err_reg ? '0 : acc_reg;
    assign err_out = err_reg;
endmodule

>>> rtl/conv2d_stride2_forward_unit.sv
// Channel       | dir | handshake        | payload
// s_ (items)    | in  | s_tvalid/tready  | s_tdata: func, filter, channel, row, col, sample
// m_ (results)  | out | m_tvalid/tready  | m_tdata: conv_sum; m_tuser: range_error
// cfg (regs)    | in  | cfg_valid/ready  | cfg_index, cfg_data
// Loads wait while a queued or running compute still reads the stores.
// A compute holds the back part for the pop, one MAC per tap, the drain of the read and
// multiply stages, and the result, held until m_tready; a rejected request goes from the
// pop to the result. Two jobs may queue; a compute stalls only on a full queue.
// aresetn is synchronous; stores are not cleared.
module conv2d_stride2_forward_unit #(
    parameter int MAX_CHANNELS = c2s_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_HEIGHT   = c2s_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = c2s_pkg::MAX_WIDTH_DEF,
    parameter int MAX_FILTERS  = c2s_pkg::MAX_FILTERS_DEF,
    parameter int MAX_KERNEL   = c2s_pkg::MAX_KERNEL_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // func[1:0], filter_index[5:2], channel_index[9:6], row_index[14:10],
    // col_index[19:15], sample_value[35:20], zero fill
    input  logic [c2s_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // conv_sum[47:0]
    output logic [47:0]              m_tdata,
    // range_error[0]
    output logic                     m_tuser,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [5:0]               cfg_data
);
    import c2s_pkg::*;
    localparam int W_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int I_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int WA = $clog2(W_DEPTH);
    localparam int IA = $clog2(I_DEPTH);

    logic [4:0] nch_reg, nf_reg;
    logic [5:0] ih_reg, iw_reg;
    logic [2:0] kh_reg, kw_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nch_reg <= 5'd1;
            ih_reg <= 6'd32;
            iw_reg <= 6'd32;
            nf_reg <= 5'd1;
            kh_reg <= 3'd3;
            kw_reg <= 3'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NUM_CHANNELS:  nch_reg <= cfg_data[4:0];
                CFG_IMAGE_HEIGHT:  ih_reg <= cfg_data;
                CFG_IMAGE_WIDTH:   iw_reg <= cfg_data;
                CFG_NUM_FILTERS:   nf_reg <= cfg_data[4:0];
                CFG_KERNEL_HEIGHT: kh_reg <= cfg_data[2:0];
                CFG_KERNEL_WIDTH:  kw_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    logic          w_we, i_we, job_push, job_full, job_pop, job_empty, back_busy;
    logic [WA-1:0] w_waddr, w_raddr;
    logic [IA-1:0] i_waddr, i_raddr;
    logic [15:0]   wr_data, w_rdata, i_rdata;
    job_t          job_in, job_out;

    c2s_front #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH),
        .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL)
    ) u_front (
        .s_tvalid, .s_tready, .s_tdata,
        .num_channels(nch_reg), .image_height(ih_reg), .image_width(iw_reg),
        .num_filters(nf_reg), .kernel_height(kh_reg), .kernel_width(kw_reg),
        .w_we, .w_waddr, .i_we, .i_waddr, .wr_data,
        .job_push, .job(job_in), .job_full, .job_empty, .back_busy
    );

    c2s_queue #(.DEPTH(2)) u_queue (
        .aclk, .aresetn, .push(job_push), .din(job_in), .full(job_full),
        .pop(job_pop), .empty(job_empty), .dout(job_out)
    );

    c2s_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wram (
        .aclk, .we(w_we), .waddr(w_waddr), .wdata(wr_data),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    c2s_ram #(.WIDTH(16), .DEPTH(I_DEPTH)) u_iram (
        .aclk, .we(i_we), .waddr(i_waddr), .wdata(wr_data),
        .raddr(i_raddr), .rdata(i_rdata)
    );

    c2s_back #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_HEIGHT(MAX_HEIGHT), .MAX_WIDTH(MAX_WIDTH),
        .MAX_FILTERS(MAX_FILTERS), .MAX_KERNEL(MAX_KERNEL)
    ) u_back (
        .aclk, .aresetn, .job_empty, .job(job_out), .job_pop, .busy(back_busy),
        .num_channels(nch_reg), .kernel_height(kh_reg), .kernel_width(kw_reg),
        .w_raddr, .w_rdata, .i_raddr, .i_rdata,
        .m_tvalid, .m_tready, .sum_out(m_tdata), .err_out(m_tuser)
    );
endmodule

>>> rtl/c2s_checker.sv
// Port-level checker for the convolution unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module c2s_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_ready
);
    `ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 48'd0)
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `ASSERT_NEXT(a_one_beat, aclk, aresetn, m_tvalid && m_tready, !m_tvalid)
    `ASSERT_IMPLIES(a_cfg_rdy, aclk, aresetn, 1'b1, cfg_ready)
endmodule

bind conv2d_stride2_forward_unit c2s_checker u_chk (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_ready
);
